### src/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg: shared types and constants of the shortest-job-first scheduler
// Job table sizing, field widths and the structs passed between the
// control unit and the selection unit.
// ----------------------------------------------------------------------------
package sjf_pkg;

	localparam int MAX_JOBS = 64;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int FIELD_W  = 16;
	localparam int TIME_W   = 23;
	localparam int TOT_W    = 29;

	typedef struct packed {
		logic [FIELD_W-1:0] job_id;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] burst;
	} entry_t;

	typedef struct packed {
		entry_t           ent;
		logic [IDX_W-1:0] idx;
	} cand_t;

	// Control toward the selection unit for one table beat.
	typedef struct packed {
		logic             clr;
		logic             vld;
		logic             sched;
		logic [IDX_W-1:0] idx;
	} pick_ctl_t;

	typedef struct packed {
		logic  found;
		cand_t win;
	} pick_res_t;

endpackage

### src/sjf_if.sv
// ----------------------------------------------------------------------------
// sjf_if: job and result channels of the scheduler
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sjf_job_if;
	import sjf_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] job_id;
	logic [FIELD_W-1:0] arrival_time;
	logic [FIELD_W-1:0] burst_time;
	logic               last_job;

	modport source (output valid, job_id, arrival_time, burst_time, last_job, input ready);
	modport sink (input valid, job_id, arrival_time, burst_time, last_job, output ready);
endinterface

interface sjf_res_if;
	import sjf_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] job_id_res;
	logic [FIELD_W-1:0] arrival_time_res;
	logic [FIELD_W-1:0] burst_time_res;
	logic [TIME_W-1:0]  completion_time;
	logic [TIME_W-1:0]  turnaround_time;
	logic [TIME_W-1:0]  waiting_time;
	logic [TIME_W-1:0]  response_time;
	logic [TOT_W-1:0]   total_waiting;
	logic [TOT_W-1:0]   total_turnaround;
	logic               jobs_dropped;
	logic               last_result;

	modport source (output valid, job_id_res, arrival_time_res, burst_time_res,
		completion_time, turnaround_time, waiting_time, response_time,
		total_waiting, total_turnaround, jobs_dropped, last_result, input ready);
	modport sink (input valid, job_id_res, arrival_time_res, burst_time_res,
		completion_time, turnaround_time, waiting_time, response_time,
		total_waiting, total_turnaround, jobs_dropped, last_result, output ready);
endinterface

### src/shortest_job_first_scheduler_top.sv
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_top: non-preemptive shortest-job-first
// Loads a batch of jobs into a table memory, then emits the schedule.
// ----------------------------------------------------------------------------
// Jobs enter on the job channel, one beat per cycle while loading. Each job
// is written into a table memory of MAX_JOBS entries, and its scheduled flag
// in a flag memory is cleared at the same time. Jobs beyond that are dropped
// and reported in jobs_dropped. A beat with last_job set closes the batch
// and starts scheduling; job.ready stays low until the final result of the
// batch has been taken.
// For each result the control unit sweeps the table once, one read per
// cycle, while the selection unit tracks the best candidate. A result of a
// batch of n jobs goes through n reads, the last read data reaching the
// selection unit, the read pipeline draining, computing the times and
// presenting the beat. The table sweep sets the pace of results.
// The result is held in an output register; while res.ready is low the
// block holds the beat and waits. Totals are zero on every result but the last.
// Reset clears the job count, the clock and the overflow flag; table and
// flag contents need no clearing, since only loaded entries are read. After
// the last result the block returns to loading.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_top (
	input  logic     clk,
	input  logic     arst_n,
	sjf_job_if.sink  job,
	sjf_res_if.source res
);
	import sjf_pkg::*;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	entry_t              mem [MAX_JOBS];
	logic                mark_mem [MAX_JOBS];
	entry_t              rd_data_s1;
	logic                sched_s1;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic [CNT_W-1:0]    k_q;
	logic [TIME_W-1:0]   clock_q;
	logic                ovf_q;
	logic [TOT_W-1:0]    tot_wait_q;
	logic [TOT_W-1:0]    tot_tat_q;

	entry_t              out_ent_q;
	logic [TIME_W-1:0]   done_q;
	logic [TIME_W-1:0]   tat_q;
	logic [TIME_W-1:0]   wait_q;
	logic [TOT_W-1:0]    out_tw_q;
	logic [TOT_W-1:0]    out_tt_q;
	logic                out_drop_q;
	logic                out_last_q;

	logic                job_acc;
	logic                has_room;
	logic                issue;
	logic                clr_pick;
	pick_ctl_t           ctl;
	pick_res_t           pick;
	logic [TIME_W-1:0]   arr_w;
	logic [TIME_W-1:0]   start_w;
	logic [TIME_W-1:0]   done_w;
	logic [TIME_W-1:0]   tat_w;
	logic [TIME_W-1:0]   wait_w;
	logic [TOT_W-1:0]    tw_sum;
	logic [TOT_W-1:0]    tt_sum;
	logic                last_w;

	assign job.ready = (state_q == ST_LOAD);
	assign job_acc   = job.valid && job.ready;
	assign has_room  = count_q < CNT_W'(MAX_JOBS);
	assign issue     = (state_q == ST_SCAN) && (rd_cnt_q < count_q);
	assign clr_pick  = (job_acc && job.last_job) ||
		((state_q == ST_EMIT) && res.ready && !out_last_q);

	// Table memory: written while loading, read during each sweep.
	always_ff @(posedge clk) begin
		if (job_acc && has_room) begin
			mem[count_q[IDX_W-1:0]] <= '{job_id: job.job_id,
				arrival: job.arrival_time, burst: job.burst_time};
		end
		rd_data_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		idx_s1     <= rd_cnt_q[IDX_W-1:0];
	end

	// Flag memory: a loaded job starts unscheduled and is marked once it
	// has been picked. The mark is written in ST_FIN, before the next sweep
	// reads the table with ST_EMIT in between, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (job_acc && has_room) begin
			mark_mem[count_q[IDX_W-1:0]] <= 1'b0;
		end else if (state_q == ST_FIN) begin
			mark_mem[pick.win.idx] <= 1'b1;
		end
		sched_s1 <= mark_mem[rd_cnt_q[IDX_W-1:0]];
	end

	always_comb begin
		ctl.clr   = clr_pick;
		ctl.vld   = vld_s1;
		ctl.sched = sched_s1;
		ctl.idx   = idx_s1;
	end

	sjf_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_data   (rd_data_s1),
		.clock_now (clock_q),
		.pick      (pick)
	);

	always_comb begin
		arr_w   = TIME_W'(pick.win.ent.arrival);
		start_w = pick.found ? clock_q : arr_w;
		done_w  = start_w + TIME_W'(pick.win.ent.burst);
		tat_w   = done_w - arr_w;
		wait_w  = start_w - arr_w;
		tw_sum  = tot_wait_q + TOT_W'(wait_w);
		tt_sum  = tot_tat_q + TOT_W'(tat_w);
		last_w  = (k_q + CNT_W'(1)) == count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			rd_cnt_q   <= '0;
			k_q        <= '0;
			clock_q    <= '0;
			ovf_q      <= 1'b0;
			tot_wait_q <= '0;
			tot_tat_q  <= '0;
			vld_s1     <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			unique case (state_q)
				ST_LOAD: begin
					if (job_acc) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (job.last_job) begin
							rd_cnt_q <= '0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end else if (!vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					clock_q    <= done_w;
					tot_wait_q <= tw_sum;
					tot_tat_q  <= tt_sum;
					k_q        <= k_q + CNT_W'(1);
					out_last_q <= last_w;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res.ready) begin
						if (out_last_q) begin
							count_q    <= '0;
							k_q        <= '0;
							clock_q    <= '0;
							ovf_q      <= 1'b0;
							tot_wait_q <= '0;
							tot_tat_q  <= '0;
							out_last_q <= 1'b0;
							state_q    <= ST_LOAD;
						end else begin
							rd_cnt_q <= '0;
							state_q  <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result payload, captured once per schedule step.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			out_ent_q  <= pick.win.ent;
			done_q     <= done_w;
			tat_q      <= tat_w;
			wait_q     <= wait_w;
			out_tw_q   <= last_w ? tw_sum : '0;
			out_tt_q   <= last_w ? tt_sum : '0;
			out_drop_q <= ovf_q;
		end
	end

	assign res.valid            = (state_q == ST_EMIT);
	assign res.job_id_res       = out_ent_q.job_id;
	assign res.arrival_time_res = out_ent_q.arrival;
	assign res.burst_time_res   = out_ent_q.burst;
	assign res.completion_time  = done_q;
	assign res.turnaround_time  = tat_q;
	assign res.waiting_time     = wait_q;
	assign res.response_time    = wait_q;
	assign res.total_waiting    = out_tw_q;
	assign res.total_turnaround = out_tt_q;
	assign res.jobs_dropped     = out_drop_q;
	assign res.last_result      = out_last_q;

endmodule

### src/sjf_pick.sv
// ----------------------------------------------------------------------------
// sjf_pick: selection unit of the scheduler
// Watches one table entry per beat and keeps two candidates: the shortest
// arrived job, and the shortest job among those with the earliest arrival.
// ----------------------------------------------------------------------------
module sjf_pick (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sjf_pkg::pick_ctl_t            ctl,
	input  sjf_pkg::entry_t               rd_data,
	input  logic [sjf_pkg::TIME_W-1:0]    clock_now,
	output sjf_pkg::pick_res_t            pick
);
	import sjf_pkg::*;

	logic  fnd_q;
	logic  have_e_q;
	cand_t f_q;
	cand_t e_q;
	logic  arrived;
	logic  take_f;
	logic  take_e;

	assign arrived = {{(TIME_W-FIELD_W){1'b0}}, rd_data.arrival} <= clock_now;

	// Strict compares keep the earlier-loaded job on a tie.
	assign take_f = ctl.vld && !ctl.sched && arrived &&
		(!fnd_q || (rd_data.burst < f_q.ent.burst));
	assign take_e = ctl.vld && !ctl.sched &&
		(!have_e_q || (rd_data.arrival < e_q.ent.arrival) ||
		((rd_data.arrival == e_q.ent.arrival) && (rd_data.burst < e_q.ent.burst)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnd_q    <= 1'b0;
			have_e_q <= 1'b0;
		end else if (ctl.clr) begin
			fnd_q    <= 1'b0;
			have_e_q <= 1'b0;
		end else begin
			if (take_f) begin
				fnd_q <= 1'b1;
			end
			if (take_e) begin
				have_e_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_f && !ctl.clr) begin
			f_q.ent <= rd_data;
			f_q.idx <= ctl.idx;
		end
		if (take_e && !ctl.clr) begin
			e_q.ent <= rd_data;
			e_q.idx <= ctl.idx;
		end
	end

	// With no job arrived, the clock jumps to the earliest arrival and the
	// shortest job of that arrival runs.
	assign pick.found = fnd_q;
	assign pick.win   = fnd_q ? f_q : e_q;

endmodule

### src/sjf_chk.sv
// ----------------------------------------------------------------------------
// sjf_chk: port-level checks of the scheduler
// Observes the job and result channels and flags inconsistent behavior.
// ----------------------------------------------------------------------------
module sjf_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         job_valid,
	input logic                         job_ready,
	input logic                         last_job,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [sjf_pkg::FIELD_W-1:0]  burst_time_res,
	input logic [sjf_pkg::TIME_W-1:0]   turnaround_time,
	input logic [sjf_pkg::TIME_W-1:0]   waiting_time,
	input logic [sjf_pkg::TIME_W-1:0]   response_time,
	input logic [sjf_pkg::TOT_W-1:0]    total_waiting,
	input logic [sjf_pkg::TOT_W-1:0]    total_turnaround,
	input logic                         last_result
);
	import sjf_pkg::*;

	// A stalled result beat stays valid and keeps its turnaround, waiting and last flag.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(turnaround_time) &&
		$stable(waiting_time) && $stable(last_result))
		else $error("result beat changed while stalled");

	// Loading and emitting never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !job_ready)
		else $error("job channel open while a result is pending");

	// Closing a batch stops the job channel right away.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready && last_job |=> !job_ready)
		else $error("job channel still open after the last job");

	// Turnaround is waiting plus burst; response equals waiting.
	a_times: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (turnaround_time == waiting_time + TIME_W'(burst_time_res)) &&
		(response_time == waiting_time))
		else $error("result times are inconsistent");

	// Totals appear on the final result only.
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last_result |-> (total_waiting == '0) && (total_turnaround == '0))
		else $error("totals present before the last result");

endmodule

bind shortest_job_first_scheduler_top sjf_chk u_sjf_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.job_valid        (job.valid),
	.job_ready        (job.ready),
	.last_job         (job.last_job),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.burst_time_res   (res.burst_time_res),
	.turnaround_time  (res.turnaround_time),
	.waiting_time     (res.waiting_time),
	.response_time    (res.response_time),
	.total_waiting    (res.total_waiting),
	.total_turnaround (res.total_turnaround),
	.last_result      (res.last_result)
);
